// ===== sv/fdmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the frame difference motion detector.
// No dependencies; imported by frame_difference_motion_detector_unit.
package fdmd_pkg;

    // Sample store depth and the widths that follow from it.
    localparam int MAX_SAMPLES = 76800;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int PIXEL_W   = 16;
    localparam int GREEN_W   = 8;
    localparam int STEP_W    = 5;
    localparam int PHASE_W   = 4;
    localparam int THR_W     = 8;
    localparam int RATIO_W   = 16;
    localparam int LIMIT_W   = 17;
    localparam int PROD_W    = RATIO_W + CNT_W;
    localparam int FRAC_BITS = 16;

    localparam logic [GREEN_W-1:0] GREEN_MASK = 8'hFC;
    localparam logic [STEP_W-1:0]  STEP_MAX   = 5'd16;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_STEP     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_THRESHOLD = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_THRESHOLD = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_LIMIT    = 8'd3;

    localparam logic [STEP_W-1:0]  SAMPLE_STEP_RST     = 5'd4;
    localparam logic [THR_W-1:0]   PIXEL_THRESHOLD_RST = 8'd20;
    localparam logic [RATIO_W-1:0] RATIO_THRESHOLD_RST = 16'd3277;
    localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RST    = 17'd19200;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic               motion_detected;
        logic [CNT_W-1:0]   changed_count;
        logic [CNT_W-1:0]   sample_count;
    } result_t;

endpackage

// ===== sv/frame_difference_motion_detector_unit.sv =====
`timescale 1ns / 1ps
// Frame difference motion detector: sample store, change counting and the
// per-frame motion decision. Depends on fdmd_pkg.
//
//  Channel   Direction  Ports                                    Payload
//  pixels    in         s_valid, s_ready, s_data                 pixel_in_t
//  results   out        m_valid, m_ready, m_data                 result_t (one per frame)
//  config    in         cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// One pixel is accepted per cycle. The sample store is one 76800 x 8 memory
// that is read and written at the same address in the accept cycle (read-first).
// A frame's result passes stage 1, stage 2 and the output register. Reset clears
// counters and the fill mark, not the store; entries at or above the mark read
// as zero, so no clearing pass is needed. Input stalls only when three frame
// results are queued behind a blocked result channel.
module frame_difference_motion_detector_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fdmd_pkg::pixel_in_t                s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fdmd_pkg::result_t                  m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fdmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fdmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fdmd_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // Configuration registers.
    logic [STEP_W-1:0]  sample_step_reg;
    logic [THR_W-1:0]   pixel_threshold_reg;
    logic [RATIO_W-1:0] ratio_threshold_reg;
    logic [LIMIT_W-1:0] sample_limit_reg;

    // Frame state.
    logic               prev_frame_valid_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [CNT_W-1:0]   taken_reg;
    logic [CNT_W-1:0]   changed_reg;
    logic [CNT_W-1:0]   fill_reg;

    logic [GREEN_W-1:0] prev_mem [MAX_SAMPLES];
    logic [GREEN_W-1:0] rd_data_reg;

    // Stage 1: compare against the stored sample.
    logic               v1_reg;
    logic               take1_reg;
    logic               last1_reg;
    logic               stored1_reg;
    logic               pfv1_reg;
    logic [GREEN_W-1:0] green1_reg;
    logic [CNT_W-1:0]   taken1_reg;

    // Stage 2: end-of-frame product.
    logic               v2_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [CNT_W-1:0]   changed2_reg;
    logic [CNT_W-1:0]   taken2_reg;

    logic               m_valid_reg;
    result_t            m_data_reg;

    logic               s_fire;
    logic               out_free;
    logic               r2;
    logic               s1_go;
    logic [STEP_W-1:0]  eff_step;
    logic [CNT_W-1:0]   eff_limit;
    logic               take;
    logic [GREEN_W-1:0] green;
    logic [ADDR_W-1:0]  addr;
    logic [STEP_W-1:0]  phase_inc;
    logic [CNT_W-1:0]   taken_inc;
    logic [GREEN_W-1:0] old_val;
    logic [GREEN_W-1:0] diff;
    logic               inc;
    logic [CNT_W-1:0]   changed_sum;
    logic [PROD_W-1:0]  lhs;

    assign cfg_ready = 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign r2       = !v2_reg || out_free;
    assign s_ready  = !v1_reg || !last1_reg || r2;
    assign s_fire   = s_valid && s_ready;
    assign s1_go    = v1_reg && (!last1_reg || r2);

    always_comb begin
        if (sample_step_reg == '0) begin
            eff_step = STEP_W'(1);
        end else if (sample_step_reg > STEP_MAX) begin
            eff_step = STEP_MAX;
        end else begin
            eff_step = sample_step_reg;
        end
        eff_limit = (sample_limit_reg > MAX_CNT) ? MAX_CNT : sample_limit_reg;
        take      = (phase_reg == '0) && (taken_reg < eff_limit);
        green     = GREEN_W'(s_data.pixel >> 3) & GREEN_MASK;
        addr      = taken_reg[ADDR_W-1:0];
        phase_inc = {1'b0, phase_reg} + STEP_W'(1);
        taken_inc = taken_reg + CNT_W'(take);
    end

    // Entries at or above the fill mark have not been written since reset and are read as zero.
    always_comb begin
        old_val     = stored1_reg ? rd_data_reg : '0;
        diff        = (green1_reg > old_val) ? (green1_reg - old_val) : (old_val - green1_reg);
        inc         = take1_reg && pfv1_reg && (diff > pixel_threshold_reg);
        changed_sum = changed_reg + CNT_W'(inc);
        lhs         = {changed2_reg, FRAC_BITS'(0)};
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= prev_mem[addr];
            if (take) begin
                prev_mem[addr] <= green;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_step_reg     <= SAMPLE_STEP_RST;
            pixel_threshold_reg <= PIXEL_THRESHOLD_RST;
            ratio_threshold_reg <= RATIO_THRESHOLD_RST;
            sample_limit_reg    <= SAMPLE_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SAMPLE_STEP:     sample_step_reg     <= cfg_data[STEP_W-1:0];
                REG_PIXEL_THRESHOLD: pixel_threshold_reg <= cfg_data[THR_W-1:0];
                REG_RATIO_THRESHOLD: ratio_threshold_reg <= cfg_data[RATIO_W-1:0];
                REG_SAMPLE_LIMIT:    sample_limit_reg    <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept stage: sampling decision, counters and fill mark.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_frame_valid_reg <= 1'b0;
            phase_reg            <= '0;
            taken_reg            <= '0;
            fill_reg             <= '0;
            v1_reg               <= 1'b0;
        end else begin
            if (s_fire) begin
                if (s_data.last_of_frame) begin
                    prev_frame_valid_reg <= 1'b1;
                    phase_reg            <= '0;
                    taken_reg            <= '0;
                end else begin
                    phase_reg <= (phase_inc >= eff_step) ? '0 : phase_inc[PHASE_W-1:0];
                    taken_reg <= taken_inc;
                end
                if (take && taken_reg >= fill_reg) begin
                    fill_reg <= taken_inc;
                end
                v1_reg <= 1'b1;
            end else if (s1_go) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            take1_reg   <= take;
            last1_reg   <= s_data.last_of_frame;
            stored1_reg <= taken_reg < fill_reg;
            pfv1_reg    <= prev_frame_valid_reg;
            green1_reg  <= green;
            taken1_reg  <= taken_inc;
        end
    end

    // Compare stage and end-of-frame product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            changed_reg <= '0;
            v2_reg      <= 1'b0;
        end else begin
            if (s1_go) begin
                changed_reg <= last1_reg ? '0 : changed_sum;
            end
            if (s1_go && last1_reg) begin
                v2_reg <= 1'b1;
            end else if (out_free) begin
                v2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && last1_reg) begin
            prod2_reg    <= PROD_W'(ratio_threshold_reg) * PROD_W'(taken1_reg);
            changed2_reg <= changed_sum;
            taken2_reg   <= taken1_reg;
        end
    end

    // Output register: motion when samples are nonzero and changed * 2^16 exceeds ratio * samples.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && v2_reg) begin
            m_data_reg.motion_detected <= (taken2_reg != '0) && (lhs > prod2_reg);
            m_data_reg.changed_count   <= changed2_reg;
            m_data_reg.sample_count    <= taken2_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_changed_le_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.changed_count <= m_data.sample_count)
        else $error("changed count exceeds sample count");

    a_no_motion_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sample_count == '0 |-> !m_data.motion_detected)
        else $error("motion reported for a frame without samples");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= MAX_CNT && taken_reg <= MAX_CNT)
        else $error("sample index beyond store depth");

    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !out_free |=> v2_reg && $stable(prod2_reg) && $stable(taken2_reg))
        else $error("pending frame result lost while output blocked");

    a_first_frame_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !prev_frame_valid_reg && !v1_reg |-> changed_reg == '0)
        else $error("changes counted before a previous frame exists");
`endif

endmodule

// ===== tb/sv/frame_difference_motion_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frame_difference_motion_detector_unit: pixel driver,
// result monitor and a frame-differencing predictor. Depends on fdmd_pkg.
module frame_difference_motion_detector_unit_tb;
    import fdmd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PERCENT  = 17;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_GUARD   = 20000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 80;
    localparam int STEADY_PHASE  = 5;
    localparam int SHADOW_LEN    = 64;
    localparam int REPORT_LIMIT  = 10;
    localparam int G_W           = GREEN_W - 2;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = CFG_INDEX_W'(REG_SAMPLE_LIMIT + 1);
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    pixel_in_t s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    result_t   m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    frame_difference_motion_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Predictor state: register copies and the per-frame sample history.
    logic [STEP_W-1:0]  step_reg  = SAMPLE_STEP_RST;
    logic [THR_W-1:0]   thr_reg   = PIXEL_THRESHOLD_RST;
    logic [RATIO_W-1:0] ratio_reg = RATIO_THRESHOLD_RST;
    logic [LIMIT_W-1:0] limit_reg = SAMPLE_LIMIT_RST;
    bit [GREEN_W-1:0]   prev_green [MAX_SAMPLES];
    bit                 have_prev_frame = 1'b0;
    int unsigned        step_phase      = 0;
    int unsigned        taken           = 0;
    int unsigned        changed         = 0;

    pixel_in_t   pixel_queue [$];
    result_t     frame_reports [$];
    bit [PIXEL_W-1:0] shadow [SHADOW_LEN];

    bit steady = 1'b0;
    int mismatch_count = 0;
    int pixels_sent    = 0;
    int frames_checked = 0;
    int reg_writes     = 0;
    int setting_count  = 0;

    function automatic void note_mismatch(input string what, input result_t want,
                                          input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: expected motion=%0b changed=%0d samples=%0d, got motion=%0b changed=%0d samples=%0d",
                     what, want.motion_detected, want.changed_count, want.sample_count,
                     got.motion_detected, got.changed_count, got.sample_count);
    endfunction

    // Updates the frame history for one accepted pixel and queues the frame
    // report when the pixel closes the frame.
    function automatic void account_pixel(input pixel_in_t item);
        int unsigned        step;
        int unsigned        lim;
        logic [GREEN_W-1:0] green;
        logic [GREEN_W-1:0] old;
        logic [GREEN_W-1:0] diff;
        longint unsigned    lhs;
        longint unsigned    rhs;
        result_t            report;
        step = (step_reg == 0) ? 1 : ((step_reg > STEP_MAX) ? STEP_MAX : step_reg);
        lim  = (limit_reg > MAX_SAMPLES) ? MAX_SAMPLES : limit_reg;
        if (step_phase == 0 && taken < lim) begin
            green = item.pixel[10:3] & GREEN_MASK;
            old   = prev_green[taken];
            diff  = (green > old) ? green - old : old - green;
            if (have_prev_frame && diff > thr_reg)
                changed++;
            prev_green[taken] = green;
            taken++;
        end
        if (step_phase + 1 >= step)
            step_phase = 0;
        else
            step_phase++;
        if (item.last_of_frame) begin
            lhs = 64'(changed);
            lhs = lhs << FRAC_BITS;
            rhs = 64'(ratio_reg);
            rhs = rhs * taken;
            report.motion_detected = (taken != 0) && (lhs > rhs);
            report.changed_count   = CNT_W'(changed);
            report.sample_count    = CNT_W'(taken);
            frame_reports.push_back(report);
            have_prev_frame = 1'b1;
            step_phase = 0;
            taken      = 0;
            changed    = 0;
        end
    endfunction

    // Pixel driver: holds the payload until accepted, idles at random outside the steady phase.
    always @(posedge aclk) begin : pixel_driver
        bit holding;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                account_pixel(s_data);
                void'(pixel_queue.pop_front());
                pixels_sent++;
            end
            if (holding) begin
            end else if (pixel_queue.size() != 0 &&
                         (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                s_valid <= 1'b1;
                s_data  <= pixel_queue[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: every transaction must match the oldest frame report.
    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_reports.size() == 0) begin
                    note_mismatch("Unexpected result", '0, m_data);
                end else begin
                    want = frame_reports.pop_front();
                    if (m_data.motion_detected !== want.motion_detected ||
                        m_data.changed_count !== want.changed_count ||
                        m_data.sample_count !== want.sample_count)
                        note_mismatch("Wrong result", want, m_data);
                    frames_checked++;
                end
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_SAMPLE_STEP:     step_reg  = val[STEP_W-1:0];
            REG_PIXEL_THRESHOLD: thr_reg   = val[THR_W-1:0];
            REG_RATIO_THRESHOLD: ratio_reg = val[RATIO_W-1:0];
            REG_SAMPLE_LIMIT:    limit_reg = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every pixel is taken and every report has come back, then
    // lets the pipeline settle so the block is idle.
    task automatic drain();
        int guard;
        guard = 0;
        while ((pixel_queue.size() != 0 || s_valid || frame_reports.size() != 0) &&
               guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_pixel(input logic [PIXEL_W-1:0] px, input logic last);
        pixel_in_t item;
        item.pixel         = px;
        item.last_of_frame = last;
        pixel_queue.push_back(item);
    endtask

    // Similar frames reuse the earlier frame's pixels with small green shifts,
    // so the change count lands near the thresholds.
    task automatic queue_frame(input int len, input bit similar, input bit closed,
                               input bit noisy);
        pixel_in_t             item;
        logic [G_W-1:0]        g;
        for (int i = 0; i < len; i++) begin
            item.pixel = PIXEL_W'($urandom);
            if (similar && i < SHADOW_LEN) begin
                g = shadow[i][10:5];
                if ($urandom_range(0, 3) != 0)
                    g = G_W'(g + $urandom_range(0, 24) - 12);
                item.pixel[10:5] = g;
            end
            if (i < SHADOW_LEN)
                shadow[i] = item.pixel;
            item.last_of_frame = (closed && i == len - 1) ||
                                 (noisy && $urandom_range(0, 5) == 0);
            pixel_queue.push_back(item);
        end
    endtask

    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] upper;
        logic [STEP_W-1:0]     step_val;
        logic [THR_W-1:0]      thr_val;
        logic [RATIO_W-1:0]    ratio_val;
        logic [LIMIT_W-1:0]    limit_val;
        int unsigned           roll;
        upper = CFG_DATA_W'($urandom);
        roll  = $urandom_range(0, 9);
        if (roll == 0)
            step_val = '0;
        else if (roll == 1)
            step_val = STEP_W'($urandom_range(STEP_MAX, 31));
        else
            step_val = STEP_W'($urandom_range(1, 6));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            thr_val = '0;
        else if (roll == 1)
            thr_val = '1;
        else
            thr_val = THR_W'($urandom_range(0, 60));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            ratio_val = '0;
        else if (roll == 1)
            ratio_val = '1;
        else if (roll < 6)
            ratio_val = RATIO_W'($urandom_range(0, 20000));
        else
            ratio_val = RATIO_W'($urandom);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            limit_val = '0;
        else if (roll == 1)
            limit_val = LIMIT_W'($urandom_range(MAX_SAMPLES, (1 << LIMIT_W) - 1));
        else if (roll == 2)
            limit_val = LIMIT_W'($urandom_range(25, 200));
        else
            limit_val = LIMIT_W'($urandom_range(1, 24));
        write_reg(REG_SAMPLE_STEP, {upper[CFG_DATA_W-1:STEP_W], step_val});
        write_reg(REG_PIXEL_THRESHOLD, {upper[CFG_DATA_W-1:THR_W], thr_val});
        write_reg(REG_RATIO_THRESHOLD, {upper[CFG_DATA_W-1:RATIO_W], ratio_val});
        write_reg(REG_SAMPLE_LIMIT, limit_val);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      CFG_DATA_W'($urandom));
        setting_count++;
    endtask

    initial begin : stimulus
        int queued;
        int len;
        int kind;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First frame after reset under the reset settings: stored, never changed.
        setting_count++;
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'h1234, 1'b0);
        queue_pixel(16'h5678, 1'b0);
        queue_pixel(16'h07E0, 1'b1);
        drain();

        // A step of zero acts as one; the limit of three cuts the frame short.
        write_reg(REG_SAMPLE_STEP, 17'h1FFE0);
        write_reg(REG_PIXEL_THRESHOLD, '0);
        write_reg(REG_RATIO_THRESHOLD, '0);
        write_reg(REG_SAMPLE_LIMIT, 17'd3);
        setting_count++;
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'h07E0, 1'b0);
        queue_pixel(16'hF81F, 1'b0);
        queue_pixel(16'hFFFF, 1'b1);
        drain();

        // Empty sample set with the threshold and ratio at their tops.
        write_reg(REG_SAMPLE_LIMIT, '0);
        write_reg(REG_PIXEL_THRESHOLD, {{(CFG_DATA_W - THR_W){1'b0}}, {THR_W{1'b1}}});
        write_reg(REG_RATIO_THRESHOLD, {{(CFG_DATA_W - RATIO_W){1'b0}}, {RATIO_W{1'b1}}});
        setting_count++;
        queue_pixel(16'hAAAA, 1'b0);
        queue_pixel(16'h5555, 1'b1);
        drain();

        // Oversized step and limit, plus writes to unused indexes; the frame is
        // left open so the next step takes effect mid-frame.
        write_reg(REG_SAMPLE_STEP, 17'h0001F);
        write_reg(REG_SAMPLE_LIMIT, '1);
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, '1);
        setting_count++;
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'h0000, 1'b0);
        drain();

        write_reg(REG_SAMPLE_STEP, 17'd2);
        write_reg(REG_PIXEL_THRESHOLD, CFG_DATA_W'(PIXEL_THRESHOLD_RST));
        write_reg(REG_RATIO_THRESHOLD, CFG_DATA_W'(RATIO_THRESHOLD_RST));
        setting_count++;
        queue_pixel(16'h07E0, 1'b0);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'hFFFF, 1'b1);
        drain();

        // Random phases: mostly well-formed frames, some noisy or left open.
        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            pick_settings();
            steady = (phase_no == STEADY_PHASE);
            queued = 0;
            while (queued < PHASE_PIXELS) begin
                len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 40);
                kind = $urandom_range(0, 9);
                queue_frame(len, kind < 6, kind != 9, kind == 8);
                queued += len;
            end
            drain();
            steady = 1'b0;
        end

        while (frame_reports.size() != 0)
            note_mismatch("Missing result", frame_reports.pop_front(), '0);
        $display("Drove %0d pixels under %0d settings with %0d register writes.",
                 pixels_sent, setting_count, reg_writes);
        $display("Checked %0d frame reports; %0d mismatches.", frames_checked,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("Timeout waiting for the block to finish.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fdmd_pkg.sv
sv/frame_difference_motion_detector_unit.sv
tb/sv/frame_difference_motion_detector_unit_tb.sv
